>>> hw/rtl/pidw_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pidw_pkg
// Widths, register indexes, reset values and unit request/response types
// shared by the wrapped-error servo controller.
// ---------------------------------------------------------------------------
package pidw_pkg;

  localparam int WORD_BITS   = 32;
  localparam int MEAS_W      = 20;
  localparam int GAIN_W      = 16;
  localparam int PERIOD_W    = 16;
  localparam int ERR_W       = 23;
  localparam int DRIVE_W     = 32;

  localparam int DERIV_SCALE = 100;

  // divisor path carries period*100 or the scale divisor
  localparam int DIV_W       = PERIOD_W + $clog2(DERIV_SCALE + 1);
  // multiplicand holds the error, period*error, the error difference times 100 or a quotient, sign extended
  localparam int MUL_X_W     = ERR_W + GAIN_W + 1;
  localparam int PROD_W      = MUL_X_W + GAIN_W;
  localparam int MUL_CNT_W   = $clog2(GAIN_W + 1);
  localparam int DIV_CNT_W   = $clog2(WORD_BITS + 1);

  // configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_IDX_W-1:0] REG_KP     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KD     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SPAN   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(5);

  localparam logic [GAIN_W-1:0] KP_RESET     = GAIN_W'(3000);
  localparam logic [GAIN_W-1:0] KI_RESET     = GAIN_W'(1);
  localparam logic [GAIN_W-1:0] KD_RESET     = GAIN_W'(9000);
  localparam logic [GAIN_W-1:0] SCALE_RESET  = GAIN_W'(10000);
  localparam logic [MEAS_W-1:0] SPAN_RESET   = MEAS_W'(4096);
  localparam logic [MEAS_W-1:0] OFFSET_RESET = MEAS_W'(2048);

  typedef struct packed {
    logic               start;
    logic [MUL_X_W-1:0] x;
    logic [GAIN_W-1:0]  y;
  } pidw_mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
  } pidw_mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] dividend;
    logic [DIV_W-1:0]     divisor;
  } pidw_div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [WORD_BITS-1:0] quo;
  } pidw_div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/pidw_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pidw_if
// Valid/ready channels of the servo controller: sample in, drive out.
// ---------------------------------------------------------------------------
interface pidw_in_if import pidw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MEAS_W-1:0]   measured;
  logic [MEAS_W-1:0]   setpoint;
  logic [PERIOD_W-1:0] period;

  modport source (output valid, output measured, output setpoint, output period,
                  input ready);
  modport sink   (input valid, input measured, input setpoint, input period,
                  output ready);
endinterface

interface pidw_out_if import pidw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      prop_overflow;
  logic                      integ_overflow;

  modport source (output valid, output drive, output prop_overflow,
                  output integ_overflow, input ready);
  modport sink   (input valid, input drive, input prop_overflow,
                  input integ_overflow, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pid_servo_wrapped_error.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pid_servo_wrapped_error
// PID servo with wrap-around error selection, built on a serial multiplier
// and a serial divider driven by one sequencer.
// ---------------------------------------------------------------------------
// Usage: a sample word (measured, setpoint, period) enters on in_ch when
// valid and ready are both high; one drive word leaves on out_ch for each
// sample, with the proportional and integral fallback flags.
// Gains, scale divisor, input span and output offset are written on the
// cfg port (cfg_we, cfg_index, cfg_data); the user must do so only while
// no sample is in flight, as the block itself does not enforce it.
// Each sample runs as a chain of operations on one shift-add multiplier
// (16 steps) and one radix-2 divider (32 steps), one after another. A
// typical sample needs four multiplies and three divides; the proportional
// fallback adds one divide and one multiply, the integral fallback one
// multiply, and a zero period drops one multiply and one divide.
// The next sample is taken once the result sits in the output register,
// so a stalled receiver holds one finished word while the next sample is
// computed; that sample then waits until the word is taken.
// Reset (rst_n low, synchronous) restores the register defaults and
// clears the previous error, the integral sum and the output valid.
// ---------------------------------------------------------------------------
module pid_servo_wrapped_error import pidw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pidw_in_if.sink                    in_ch,
  pidw_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_PM, S_PFD, S_PFM, S_IM1, S_IM2, S_IFD, S_IFM,
    S_ID, S_D0, S_DM, S_DD, S_R, S_RD, S_OUT
  } state_t;

  // configuration
  logic [GAIN_W-1:0] kp_r, ki_r, kd_r, scale_r;
  logic [MEAS_W-1:0] span_r, offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= KP_RESET;
      ki_r     <= KI_RESET;
      kd_r     <= KD_RESET;
      scale_r  <= SCALE_RESET;
      span_r   <= SPAN_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:     kp_r     <= cfg_data[GAIN_W-1:0];
        REG_KI:     ki_r     <= cfg_data[GAIN_W-1:0];
        REG_KD:     kd_r     <= cfg_data[GAIN_W-1:0];
        REG_SCALE:  scale_r  <= cfg_data[GAIN_W-1:0];
        REG_SPAN:   span_r   <= cfg_data[MEAS_W-1:0];
        REG_OFFSET: offset_r <= cfg_data[MEAS_W-1:0];
        default:    ;
      endcase
    end
  end

  function automatic logic [MUL_X_W-1:0] err_to_x(input logic [ERR_W-1:0] v);
    return {{(MUL_X_W-ERR_W){v[ERR_W-1]}}, v};
  endfunction

  function automatic logic [WORD_BITS-1:0] err_to_word(input logic [ERR_W-1:0] v);
    return {{(WORD_BITS-ERR_W){v[ERR_W-1]}}, v};
  endfunction

  function automatic logic [MUL_X_W-1:0] word_to_x(input logic [WORD_BITS-1:0] v);
    return {{(MUL_X_W-WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  function automatic logic word_fits(input logic [PROD_W-1:0] p);
    return (&p[PROD_W-1:WORD_BITS-1]) | ~(|p[PROD_W-1:WORD_BITS-1]);
  endfunction

  function automatic logic [ERR_W-1:0] mag(input logic [ERR_W-1:0] v);
    return v[ERR_W-1] ? -v : v;
  endfunction

  state_t                state_r, state_nxt;
  logic [MEAS_W-1:0]     m_r, sp_r, m_nxt, sp_nxt;
  logic [PERIOD_W-1:0]   per_r, per_nxt;
  logic [ERR_W-1:0]      e_r, eprev_r, e_nxt, eprev_nxt;
  logic [DIV_W-1:0]      sdiv_r, per100_r, sdiv_nxt, per100_nxt;
  logic [MUL_X_W-1:0]    pe_r, pe_nxt;
  logic [WORD_BITS-1:0]  p_r, d_r, integ_r, res_r;
  logic [WORD_BITS-1:0]  p_nxt, d_nxt, integ_nxt, res_nxt;
  logic                  povf_r, iovf_r, povf_nxt, iovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic                  out_povf_r, out_iovf_r, out_povf_nxt, out_iovf_nxt;

  pidw_mul_req_t mul_req_r, mul_req_nxt;
  pidw_mul_rsp_t mul_rsp;
  pidw_div_req_t div_req_r, div_req_nxt;
  pidw_div_rsp_t div_rsp;

  logic [ERR_W-1:0]   c0, c1, c3, err_pick;
  logic [ERR_W:0]     diff;
  logic [MUL_X_W-1:0] diff_x, diff100;
  logic [DIV_W-1:0]   per100;
  logic               prod_fits;

  always_comb begin
    c0 = ERR_W'(sp_r) - ERR_W'(m_r);
    c1 = c0 - ERR_W'(span_r);
    c3 = c0 + ERR_W'(span_r);
    // ties keep the earlier candidate
    err_pick = c0;
    if (mag(c1) < mag(err_pick)) begin
      err_pick = c1;
    end
    if (mag(c3) < mag(err_pick)) begin
      err_pick = c3;
    end
    diff      = {e_r[ERR_W-1], e_r} - {eprev_r[ERR_W-1], eprev_r};
    diff_x    = {{(MUL_X_W-ERR_W-1){diff[ERR_W]}}, diff};
    diff100   = MUL_X_W'(diff_x * MUL_X_W'(DERIV_SCALE));
    per100    = DIV_W'(DIV_W'(per_r) * DIV_W'(DERIV_SCALE));
    prod_fits = word_fits(mul_rsp.prod);
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    sp_nxt        = sp_r;
    per_nxt       = per_r;
    e_nxt         = e_r;
    eprev_nxt     = eprev_r;
    sdiv_nxt      = sdiv_r;
    per100_nxt    = per100_r;
    pe_nxt        = pe_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    integ_nxt     = integ_r;
    res_nxt       = res_r;
    povf_nxt      = povf_r;
    iovf_nxt      = iovf_r;
    drive_nxt     = drive_r;
    out_povf_nxt  = out_povf_r;
    out_iovf_nxt  = out_iovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mul_req_nxt       = mul_req_r;
    mul_req_nxt.start = 1'b0;
    div_req_nxt       = div_req_r;
    div_req_nxt.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          m_nxt     = in_ch.measured;
          sp_nxt    = in_ch.setpoint;
          per_nxt   = in_ch.period;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        e_nxt       = err_pick;
        sdiv_nxt    = (scale_r == '0) ? DIV_W'(1) : DIV_W'(scale_r);
        per100_nxt  = per100;
        mul_req_nxt = '{start: 1'b1, x: err_to_x(err_pick), y: kp_r};
        state_nxt   = S_PM;
      end
      S_PM: begin
        if (mul_rsp.done) begin
          povf_nxt = ~prod_fits;
          p_nxt    = mul_rsp.prod[WORD_BITS-1:0];
          if (!prod_fits) begin
            div_req_nxt = '{start: 1'b1, dividend: err_to_word(e_r), divisor: sdiv_r};
            state_nxt   = S_PFD;
          end else begin
            mul_req_nxt = '{start: 1'b1, x: err_to_x(e_r), y: per_r};
            state_nxt   = S_IM1;
          end
        end
      end
      S_PFD: begin
        if (div_rsp.done) begin
          mul_req_nxt = '{start: 1'b1, x: word_to_x(div_rsp.quo), y: kp_r};
          state_nxt   = S_PFM;
        end
      end
      S_PFM: begin
        if (mul_rsp.done) begin
          p_nxt       = mul_rsp.prod[WORD_BITS-1:0];
          mul_req_nxt = '{start: 1'b1, x: err_to_x(e_r), y: per_r};
          state_nxt   = S_IM1;
        end
      end
      S_IM1: begin
        if (mul_rsp.done) begin
          // period*error is exact in the multiplicand width
          pe_nxt      = mul_rsp.prod[MUL_X_W-1:0];
          mul_req_nxt = '{start: 1'b1, x: mul_rsp.prod[MUL_X_W-1:0], y: ki_r};
          state_nxt   = S_IM2;
        end
      end
      S_IM2: begin
        if (mul_rsp.done) begin
          iovf_nxt = ~prod_fits;
          if (!prod_fits) begin
            div_req_nxt = '{start: 1'b1, dividend: pe_r[WORD_BITS-1:0],
                            divisor: sdiv_r};
            state_nxt   = S_IFD;
          end else begin
            div_req_nxt = '{start: 1'b1, dividend: mul_rsp.prod[WORD_BITS-1:0],
                            divisor: sdiv_r};
            state_nxt   = S_ID;
          end
        end
      end
      S_IFD: begin
        if (div_rsp.done) begin
          mul_req_nxt = '{start: 1'b1, x: word_to_x(div_rsp.quo), y: ki_r};
          state_nxt   = S_IFM;
        end
      end
      S_IFM: begin
        if (mul_rsp.done) begin
          integ_nxt = integ_r + mul_rsp.prod[WORD_BITS-1:0];
          state_nxt = S_D0;
        end
      end
      S_ID: begin
        if (div_rsp.done) begin
          integ_nxt = integ_r + div_rsp.quo;
          state_nxt = S_D0;
        end
      end
      S_D0: begin
        if (per_r == '0) begin
          d_nxt     = '0;
          state_nxt = S_R;
        end else begin
          mul_req_nxt = '{start: 1'b1, x: diff100, y: kd_r};
          state_nxt   = S_DM;
        end
      end
      S_DM: begin
        if (mul_rsp.done) begin
          // (num/period)/100 equals num/(period*100) under truncation
          div_req_nxt = '{start: 1'b1, dividend: mul_rsp.prod[WORD_BITS-1:0],
                          divisor: per100_r};
          state_nxt   = S_DD;
        end
      end
      S_DD: begin
        if (div_rsp.done) begin
          d_nxt     = div_rsp.quo;
          state_nxt = S_R;
        end
      end
      S_R: begin
        div_req_nxt = '{start: 1'b1, dividend: povf_r ? d_r : (p_r + d_r),
                        divisor: sdiv_r};
        state_nxt   = S_RD;
      end
      S_RD: begin
        if (div_rsp.done) begin
          res_nxt   = (povf_r ? (p_r + div_rsp.quo) : div_rsp.quo) + integ_r
                      + WORD_BITS'(offset_r);
          eprev_nxt = e_r;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          drive_nxt     = res_r[DRIVE_W-1:0];
          out_povf_nxt  = povf_r;
          out_iovf_nxt  = iovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_req_r   <= '0;
      div_req_r   <= '0;
      out_valid_r <= 1'b0;
      eprev_r     <= '0;
      integ_r     <= '0;
      povf_r      <= 1'b0;
      iovf_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mul_req_r   <= mul_req_nxt;
      div_req_r   <= div_req_nxt;
      out_valid_r <= out_valid_nxt;
      eprev_r     <= eprev_nxt;
      integ_r     <= integ_nxt;
      povf_r      <= povf_nxt;
      iovf_r      <= iovf_nxt;
      m_r         <= m_nxt;
      sp_r        <= sp_nxt;
      per_r       <= per_nxt;
      e_r         <= e_nxt;
      sdiv_r      <= sdiv_nxt;
      per100_r    <= per100_nxt;
      pe_r        <= pe_nxt;
      p_r         <= p_nxt;
      d_r         <= d_nxt;
      res_r       <= res_nxt;
      drive_r     <= drive_nxt;
      out_povf_r  <= out_povf_nxt;
      out_iovf_r  <= out_iovf_nxt;
    end
  end

  pidw_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

  pidw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive          = drive_r;
  assign out_ch.prop_overflow  = out_povf_r;
  assign out_ch.integ_overflow = out_iovf_r;

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy at once");

  a_mul_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_req_r.start |-> !mul_rsp.busy && !div_rsp.busy)
    else $error("multiply started while a unit is busy");

  a_ready_units_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(mul_rsp.busy || div_rsp.busy))
    else $error("sample accepted while an operation runs");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result word loaded outside the output state");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/pidw_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pidw_mul
// Shift-add multiplier: signed multiplicand times unsigned 16-bit gain,
// one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module pidw_mul import pidw_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pidw_mul_req_t req,
  output pidw_mul_rsp_t      rsp
);

  logic [PROD_W-1:0]    mcand_r;
  logic [GAIN_W-1:0]    mplier_r;
  logic [PROD_W-1:0]    acc_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      mcand_r  <= {{(PROD_W-MUL_X_W){req.x[MUL_X_W-1]}}, req.x};
      mplier_r <= req.y;
      acc_r    <= '0;
      cnt_r    <= MUL_CNT_W'(GAIN_W);
      busy_r   <= 1'b1;
      done_r   <= 1'b0;
    end else if (busy_r) begin
      // product is exact modulo 2^PROD_W, which holds every true product
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[GAIN_W-1:1]};
      cnt_r    <= cnt_r - MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

`default_nettype wire

>>> hw/rtl/pidw_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pidw_div
// Restoring radix-2 divider: signed word by positive divisor, quotient
// truncated toward zero, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pidw_div import pidw_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pidw_div_req_t req,
  output pidw_div_rsp_t      rsp
);

  logic [WORD_BITS-1:0] quo_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     dvs_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [WORD_BITS-1:0] res_r;

  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;
  logic                 fits;

  always_comb begin
    shifted = {rem_r, quo_r[WORD_BITS-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      neg_r  <= req.dividend[WORD_BITS-1];
      quo_r  <= req.dividend[WORD_BITS-1] ? -req.dividend : req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
      cnt_r  <= DIV_CNT_W'(WORD_BITS);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_r <= {quo_r[WORD_BITS-2:0], fits};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end else begin
        // magnitude done, restore the sign
        res_r  <= neg_r ? -quo_r : quo_r;
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = res_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_pid_servo_wrapped_error.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_pid_servo_wrapped_error
// Self-checking bench for the wrapped-error servo controller. Samples are sent
// on the input channel under changing gain, span and offset settings. An
// in-bench predictor computes each drive word and its fallback flags. Every
// drive word that leaves the block is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_pid_servo_wrapped_error;
  import pidw_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 100;

  // indexes past the register list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

  typedef struct {
    logic [DRIVE_W-1:0] drive;
    logic               prop_ovf;
    logic               integ_ovf;
  } drive_word_t;

  class servo_scoreboard;
    longint      kp, ki, kd, scale, span, offset;
    longint      prev_err, integ;
    drive_word_t drive_fifo[$];
    int          mismatches;

    function new();
      kp = longint'(KP_RESET);
      ki = longint'(KI_RESET);
      kd = longint'(KD_RESET);
      scale = longint'(SCALE_RESET);
      span = longint'(SPAN_RESET);
      offset = longint'(OFFSET_RESET);
      prev_err = 0;
      integ = 0;
      mismatches = 0;
    endfunction

    function longint wrap32(longint x);
      int t;
      t = x[31:0];
      return t;
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function int pending();
      return drive_fifo.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KP:     kp = longint'(data[GAIN_W-1:0]);
        REG_KI:     ki = longint'(data[GAIN_W-1:0]);
        REG_KD:     kd = longint'(data[GAIN_W-1:0]);
        REG_SCALE:  scale = longint'(data[GAIN_W-1:0]);
        REG_SPAN:   span = longint'(data);
        REG_OFFSET: offset = longint'(data);
        default: ;
      endcase
    endfunction

    function void note_sample(logic [MEAS_W-1:0] m_i, logic [MEAS_W-1:0] sp_i,
                              logic [PERIOD_W-1:0] per_i);
      longint      meas, tgt, per, sdiv, err, c_lo, c_hi;
      longint      prop, itrue, iterm, deriv, num, drv;
      bit          povf, iovf;
      drive_word_t w;
      meas = longint'(m_i);
      tgt = longint'(sp_i);
      per = longint'(per_i);
      sdiv = (scale == 0) ? 1 : scale;

      // least magnitude wins, ties keep the earlier candidate
      err = tgt - meas;
      c_lo = tgt - meas - span;
      c_hi = span - meas + tgt;
      if (mag(c_lo) < mag(err)) err = c_lo;
      if (mag(c_hi) < mag(err)) err = c_hi;

      prop = kp * err;
      povf = (wrap32(prop) != prop);
      if (povf) prop = wrap32(kp * (err / sdiv));

      itrue = ki * per * err;
      iovf = (wrap32(itrue) != itrue);
      if (iovf) iterm = wrap32((wrap32(per * err) / sdiv) * ki);
      else iterm = itrue / sdiv;
      integ = wrap32(integ + iterm);

      if (per == 0) begin
        deriv = 0;
      end else begin
        num = wrap32(wrap32(wrap32(err - prev_err) * 100) * kd);
        deriv = (num / per) / 100;
      end

      if (!povf) drv = wrap32(prop + deriv) / sdiv;
      else drv = wrap32(prop + deriv / sdiv);
      drv = wrap32(drv + integ);
      drv = wrap32(drv + offset);
      prev_err = err;

      w.drive = drv[DRIVE_W-1:0];
      w.prop_ovf = povf;
      w.integ_ovf = iovf;
      drive_fifo.push_back(w);
    endfunction

    function void check_drive(logic [DRIVE_W-1:0] drv, logic pov, logic iov);
      drive_word_t w;
      if (drive_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected drive word: drive=%0d prop_ovf=%b integ_ovf=%b",
                   $signed(drv), pov, iov);
        return;
      end
      w = drive_fifo.pop_front();
      if (w.drive !== drv || w.prop_ovf !== pov || w.integ_ovf !== iov) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"drive mismatch: exp drive=%0d prop=%b integ=%b,",
                    " got drive=%0d prop=%b integ=%b"},
                   $signed(w.drive), w.prop_ovf, w.integ_ovf, $signed(drv), pov, iov);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles = 0;
  servo_scoreboard sb = new();

  pidw_in_if  in_ch ();
  pidw_out_if out_ch ();

  pid_servo_wrapped_error uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_pid_servo_wrapped_error: done, errors");
      $finish;
    end
  end

  // drive word sink with random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_drive(out_ch.drive, out_ch.prop_overflow, out_ch.integ_overflow);
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_sample(input logic [MEAS_W-1:0] m, input logic [MEAS_W-1:0] sp,
                             input logic [PERIOD_W-1:0] per);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.measured <= m;
    in_ch.setpoint <= sp;
    in_ch.period <= per;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(m, sp, per);
  endtask

  task automatic random_sample();
    logic [MEAS_W-1:0]   m, sp;
    logic [PERIOD_W-1:0] per;
    int                  kind;
    kind = $urandom_range(9);
    m = MEAS_W'($urandom);
    if (kind <= 2) begin
      sp = MEAS_W'($urandom);
    end else if (kind <= 6) begin
      // tracking close to the target
      sp = m + MEAS_W'($urandom_range(4000)) - MEAS_W'(2000);
    end else begin
      // straddling the span boundary
      m = MEAS_W'($urandom_range(300));
      sp = MEAS_W'(sb.span) - MEAS_W'($urandom_range(300));
      if ($urandom_range(1)) {m, sp} = {sp, m};
    end
    case ($urandom_range(9))
      0:       per = '0;
      1:       per = PERIOD_W'($urandom);
      default: per = PERIOD_W'($urandom_range(1, 1000));
    endcase
    send_sample(m, sp, per);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // gain and scale writes carry junk in the unused upper bits
  task automatic load_settings(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                               input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] s,
                               input logic [MEAS_W-1:0] sp, input logic [MEAS_W-1:0] off);
    write_reg(REG_KP, {4'($urandom_range(15)), p});
    write_reg(REG_KI, {4'($urandom_range(15)), i});
    write_reg(REG_KD, {4'($urandom_range(15)), d});
    write_reg(REG_SCALE, {4'($urandom_range(15)), s});
    write_reg(REG_SPAN, sp);
    write_reg(REG_OFFSET, off);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.measured <= '0;
    in_ch.setpoint <= '0;
    in_ch.period <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_KP;
    cfg_data <= '0;
    send_idle_pct = 25;
    recv_idle_pct = 59;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings, span 4096
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
    send_sample(20'd0, 20'hFFFFF, 16'd1);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd4000, 20'd100, 16'd10);
    send_sample(20'd100, 20'd4000, 16'd10);
    send_sample(20'd0, 20'd2048, 16'd5);
    send_sample(20'd2048, 20'd0, 16'd5);
    send_sample(20'd1000, 20'd1010, 16'd100);
    send_sample(20'd1010, 20'd1000, 16'hFFFF);
    send_sample(20'd0, 20'd800000, 16'd0);
    send_sample(20'd0, 20'd700000, 16'd4);
    send_sample(20'd0, 20'd40000, 16'hFFFF);

    // zero gains, zero divisor, zero span
    settle();
    load_settings('0, '0, '0, '0, '0, '0);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 20'h5A5A5);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
    send_sample(20'd0, 20'hFFFFF, 16'd3);
    send_sample(20'd500, 20'd200, 16'd0);
    send_sample(20'd200, 20'd500, 16'd9);

    // everything at its maximum
    settle();
    load_settings('1, '1, '1, '1, '1, '1);
    send_sample(20'd0, 20'h80000, 16'hFFFF);
    send_sample(20'hFFFFF, 20'd0, 16'd1);
    send_sample(20'h12345, 20'hFEDCB, 16'd0);
    send_sample(20'd0, 20'h40000, 16'h8000);

    // unit divisor with large gains
    settle();
    load_settings('1, '1, '0, 16'd1, 20'd4096, '0);
    send_sample(20'd0, 20'd2000, 16'hFFFF);
    send_sample(20'd3000, 20'd0, 16'd7);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0, 1: begin
          send_idle_pct = 25;
          recv_idle_pct = 59;
        end
        2, 3: begin
          send_idle_pct = 59;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: load_settings(KP_RESET, KI_RESET, KD_RESET, SCALE_RESET, SPAN_RESET,
                         OFFSET_RESET);
        2: load_settings('1, '1, '1, '1, '1, '1);
        3: load_settings(GAIN_W'($urandom_range(50)), GAIN_W'($urandom_range(50)),
                         GAIN_W'($urandom_range(50)), 16'd1,
                         MEAS_W'($urandom_range(1, 100)), '0);
        5: load_settings(GAIN_W'($urandom), '0, '1, 16'd100, 20'd4096, 20'd2048);
        default: load_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                               GAIN_W'($urandom_range(1, 65535)),
                               MEAS_W'($urandom_range(1, 1048575)), MEAS_W'($urandom));
      endcase
      repeat (PHASE_ITEMS) random_sample();
    end

    settle();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_pid_servo_wrapped_error: done, clean");
    end else begin
      $display("tb_pid_servo_wrapped_error: done, errors");
    end
    $finish;
  end

endmodule
